// ===== hw/rtl/logistic_regression_predict_macros.svh =====
// Assertion helpers for the checker file (lrp_checker.sv).
`ifndef LOGISTIC_REGRESSION_PREDICT_MACROS_SVH
`define LOGISTIC_REGRESSION_PREDICT_MACROS_SVH

// same-cycle implication
`define LRP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lrp check failed: same-cycle implication");

// next-cycle implication
`define LRP_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lrp check failed: next-cycle implication");

`endif

// ===== hw/rtl/lrp_pkg.sv =====
package lrp_pkg;

   localparam logic MODE_WEIGHT  = 1'b0;
   localparam logic MODE_FEATURE = 1'b1;

   typedef struct packed {
      logic               mode;
      logic [5:0]         weight_index;
      logic signed [15:0] value;
      logic               last;
   } req_type;

   typedef struct packed {
      logic [15:0]        probability;
      logic signed [31:0] dot_product;
      logic               sum_saturated;
      logic               too_many_features;
   } rsp_type;

   localparam int ACC_W = 40;
   localparam logic signed [ACC_W-1:0] ACC_MAX = 40'sh7F_FFFF_FFFF;
   localparam logic signed [ACC_W-1:0] ACC_MIN = 40'sh80_0000_0000;
   localparam logic signed [31:0]      DOT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0]      DOT_MIN = 32'sh8000_0000;

   // Sigmoid over [-8,8] in Q8.24: u = z + 8.0 spans 0 .. 2^28
   localparam int SIGMOID_SEGMENTS = 32;
   localparam int SEG_BITS         = $clog2(SIGMOID_SEGMENTS);
   localparam int U_BITS           = 29;
   localparam int SEG_SHIFT        = 28 - SEG_BITS;
   localparam logic signed [32:0] HALF_RANGE = 33'sd134217728;
   localparam logic signed [32:0] FULL_RANGE = 33'sd268435456;

   // breakpoint values in Q0.16, z = -8.0 + 16 * k / SIGMOID_SEGMENTS
   localparam logic [15:0] SIG_TABLE [0:SIGMOID_SEGMENTS] = '{
      16'd22,    16'd36,    16'd60,    16'd98,    16'd162,   16'd267,
      16'd439,   16'd720,   16'd1179,  16'd1921,  16'd3108,  16'd4971,
      16'd7812,  16'd11955, 16'd17625, 16'd24743, 16'd32768, 16'd40793,
      16'd47911, 16'd53581, 16'd57724, 16'd60565, 16'd62428, 16'd63615,
      16'd64357, 16'd64816, 16'd65097, 16'd65269, 16'd65374, 16'd65438,
      16'd65476, 16'd65500, 16'd65514
   };

endpackage

// ===== hw/rtl/logistic_regression_predict.sv =====
// Logistic regression inference. A weight transaction (mode 0) writes one Q4.12 weight
// and leaves the block idle. A feature transaction (mode 1) reads the weight at the running
// position from the registered weight memory, multiplies in the shared 17x25 multiplier
// and accumulates into a 40-bit saturating sum (states MUL, ACC). The element marked
// last then passes through the steps of 32-bit clip, segment lookup, interpolation
// through the same multiplier and output load, plus any wait for the output register to empty.
// Features past MAX_FEATURES skip the multiply (clip next if last), set too_many_features.
// The result sits in an output register, so new transactions are taken while it waits.
// The weight memory has no reset; read only entries that were written.
module logistic_regression_predict #(
   parameter int MAX_FEATURES = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lrp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lrp_pkg::rsp_type rsp_data
);

   import lrp_pkg::*;

   localparam int AW = $clog2(MAX_FEATURES);
   localparam int PW = $clog2(MAX_FEATURES + 1);
   localparam int CW = (PW > 6) ? PW : 6;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_MUL    = 7'b0000010,
      S_ACC    = 7'b0000100,
      S_SAT    = 7'b0001000,
      S_LOOKUP = 7'b0010000,
      S_INTERP = 7'b0100000,
      S_DONE   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic signed [15:0]      value_ff, value_in;
   logic                    last_ff, last_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [PW-1:0]           pos_ff, pos_in;
   logic                    ovf_ff, ovf_in;
   logic signed [41:0]      prod_ff, prod_in;
   logic signed [31:0]      dot_ff, dot_in;
   logic                    clip_ff, clip_in;
   logic [15:0]             y0_ff, y0_in;
   logic [15:0]             diff_ff, diff_in;
   logic [SEG_SHIFT:0]      frac_ff, frac_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic                    accept;
   logic                    out_free;
   logic                    pos_in_range;
   logic                    widx_in_range;
   logic                    ram_we;
   logic                    ram_re;
   logic signed [15:0]      weight_rd;

   logic signed [16:0]      mul_a;
   logic signed [24:0]      mul_b;
   logic signed [41:0]      mul_p;

   logic signed [ACC_W:0]   acc_sum;
   logic signed [32:0]      u_full;
   logic [U_BITS-1:0]       u_pos;
   logic [SEG_BITS-1:0]     seg;
   logic [SEG_BITS:0]       seg_next;
   logic [15:0]             interp_add;

   assign accept        = req_valid && !req_stall;
   assign req_stall     = (state_ff != S_IDLE);
   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign pos_in_range  = (pos_ff < PW'(MAX_FEATURES));
   assign widx_in_range = (CW'(req_data.weight_index) < CW'(MAX_FEATURES));
   assign ram_we        = accept && (req_data.mode == MODE_WEIGHT) && widx_in_range;
   assign ram_re        = accept && (req_data.mode == MODE_FEATURE) && pos_in_range;

   lrp_ram #(
      .WIDTH (16),
      .DEPTH (MAX_FEATURES)
   ) u_weight_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (AW'(req_data.weight_index)),
      .wr_data (req_data.value),
      .rd_en   (ram_re),
      .rd_addr (pos_ff[AW-1:0]),
      .rd_data (weight_rd)
   );

   // shared multiplier: weight x feature, or slope x offset during interpolation
   always_comb begin
      if (state_ff == S_INTERP) begin
         mul_a = {1'b0, diff_ff};
         mul_b = 25'({1'b0, frac_ff});
      end else begin
         mul_a = {weight_rd[15], weight_rd};
         mul_b = {{9{value_ff[15]}}, value_ff};
      end
   end

   assign mul_p = mul_a * mul_b;

   assign acc_sum = {acc_ff[ACC_W-1], acc_ff} + (ACC_W+1)'($signed(prod_ff[31:0]));

   // clamp to [-8,8] and locate the segment
   assign u_full = {dot_ff[31], dot_ff} + HALF_RANGE;

   always_comb begin
      if (u_full[32]) begin
         u_pos = '0;
      end else if (u_full > FULL_RANGE) begin
         u_pos = U_BITS'(FULL_RANGE);
      end else begin
         u_pos = u_full[U_BITS-1:0];
      end
   end

   // top of the range falls in the last segment at its far end
   assign seg      = u_pos[U_BITS-1] ? '1 : u_pos[U_BITS-2:SEG_SHIFT];
   assign seg_next = {1'b0, seg} + (SEG_BITS+1)'(1);

   assign interp_add = prod_ff[SEG_SHIFT+15:SEG_SHIFT];

   always_comb begin
      state_in     = state_ff;
      value_in     = value_ff;
      last_in      = last_ff;
      acc_in       = acc_ff;
      pos_in       = pos_ff;
      ovf_in       = ovf_ff;
      prod_in      = prod_ff;
      dot_in       = dot_ff;
      clip_in      = clip_ff;
      y0_in        = y0_ff;
      diff_in      = diff_ff;
      frac_in      = frac_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_data.mode == MODE_FEATURE)) begin
               value_in = req_data.value;
               last_in  = req_data.last;
               if (pos_in_range) begin
                  state_in = S_MUL;
               end else begin
                  ovf_in = 1'b1;
                  if (req_data.last) begin
                     state_in = S_SAT;
                  end
               end
            end
         end
         S_MUL: begin
            prod_in  = mul_p;
            state_in = S_ACC;
         end
         S_ACC: begin
            if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
               acc_in = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
            end else begin
               acc_in = acc_sum[ACC_W-1:0];
            end
            pos_in   = pos_ff + PW'(1);
            state_in = last_ff ? S_SAT : S_IDLE;
         end
         S_SAT: begin
            if (acc_ff[ACC_W-1:31] == '0 || acc_ff[ACC_W-1:31] == '1) begin
               dot_in  = acc_ff[31:0];
               clip_in = 1'b0;
            end else begin
               dot_in  = acc_ff[ACC_W-1] ? DOT_MIN : DOT_MAX;
               clip_in = 1'b1;
            end
            state_in = S_LOOKUP;
         end
         S_LOOKUP: begin
            y0_in   = SIG_TABLE[seg];
            diff_in = SIG_TABLE[seg_next] - SIG_TABLE[seg];
            if (u_pos[U_BITS-1]) begin
               frac_in = {1'b1, {SEG_SHIFT{1'b0}}};
            end else begin
               frac_in = {1'b0, u_pos[SEG_SHIFT-1:0]};
            end
            state_in = S_INTERP;
         end
         S_INTERP: begin
            prod_in  = mul_p;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in                  = 1'b1;
               rsp_data_in.probability       = y0_ff + interp_add;
               rsp_data_in.dot_product       = dot_ff;
               rsp_data_in.sum_saturated     = clip_ff;
               rsp_data_in.too_many_features = ovf_ff;
               acc_in   = '0;
               pos_in   = '0;
               ovf_in   = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         acc_ff       <= '0;
         pos_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         pos_ff       <= pos_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      last_ff     <= last_in;
      prod_ff     <= prod_in;
      dot_ff      <= dot_in;
      clip_ff     <= clip_in;
      y0_ff       <= y0_in;
      diff_ff     <= diff_in;
      frac_ff     <= frac_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/lrp_ram.sv =====
module lrp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/lrp_checker.sv =====
`include "logistic_regression_predict_macros.svh"

module lrp_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input lrp_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input lrp_pkg::rsp_type rsp_data
);

   import lrp_pkg::*;

   logic feature_acc;
   logic weight_acc;

   assign feature_acc = req_valid && !req_stall && (req_data.mode == MODE_FEATURE);
   assign weight_acc  = req_valid && !req_stall && (req_data.mode == MODE_WEIGHT);

   // stalled result holds
   `LRP_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // the last feature of a vector always keeps the block busy for the result
   `LRP_ASSERT_NXT(a_feature_busy, clock, reset, feature_acc && req_data.last, req_stall)

   // weight writes leave the block ready for the next transaction
   `LRP_ASSERT_NXT(a_weight_fast, clock, reset, weight_acc, !req_stall)

   // a result is only loaded from the busy sequencer
   `LRP_ASSERT_IMP(a_rsp_from_busy, clock, reset, $rose(rsp_valid), $past(req_stall))

endmodule

bind logistic_regression_predict lrp_checker u_lrp_checker (.*);

// ===== test/tb_logistic_regression_predict.sv =====
module tb_logistic_regression_predict;
   timeunit 1ns;
   timeprecision 1ps;

   import lrp_pkg::*;

   localparam int     DEPTH    = 64;
   localparam longint ONE_Q28  = 64'sd268435456;
   localparam longint HALF_Q24 = 64'sd134217728;

   // Tracks the weight store and the running dot product, and queues
   // the expected probability transactions.
   class probability_tracker;
      logic signed [15:0] weight_mem [DEPTH];
      longint             dot_sum     = 0;
      int                 element_pos = 0;
      bit                 past_depth  = 0;
      rsp_type            expected_scores [$];
      int                 errors      = 0;

      function longint exp_whole(longint n);
         case (n)
            0: return 268435456;
            1: return 98751886;
            2: return 36328787;
            3: return 13364614;
            4: return 4916567;
            5: return 1808704;
            6: return 665385;
            7: return 244782;
            default: return 90050;
         endcase
      endfunction

      // e^-a, a in Q4.28 between 0 and 8.0
      function longint exp_neg(longint a);
         longint n, f, term, total;
         n     = a >>> 28;
         f     = a & (ONE_Q28 - 1);
         term  = ONE_Q28;
         total = ONE_Q28;
         if (n >= 8) begin
            n = 8;
            f = 0;
         end
         for (int j = 1; j <= 12; j++) begin
            term = ((term * f) >>> 28) / j;
            if (j % 2 == 1) total -= term;
            else total += term;
         end
         return (exp_whole(n) * total) >>> 28;
      endfunction

      // curve value in Q0.16 at breakpoint position p (Q8.24, z = p - 8)
      function longint curve_at(longint p);
         longint z, a, e, den, num, s;
         z   = p - HALF_Q24;
         a   = (z < 0 ? -z : z) <<< 4;
         e   = exp_neg(a);
         den = ONE_Q28 + e;
         num = (z >= 0) ? (ONE_Q28 <<< 16) : (e <<< 16);
         s   = (num + den / 2) / den;
         return s > 65535 ? 65535 : s;
      endfunction

      function longint probability_of(longint z);
         longint u, k, p0, p1, y0, y1, y;
         if (z < -HALF_Q24) z = -HALF_Q24;
         if (z > HALF_Q24) z = HALF_Q24;
         u = z + HALF_Q24;
         k = (u * SIGMOID_SEGMENTS) >>> 28;
         if (k > SIGMOID_SEGMENTS - 1) k = SIGMOID_SEGMENTS - 1;
         p0 = (k <<< 28) / SIGMOID_SEGMENTS;
         p1 = ((k + 1) <<< 28) / SIGMOID_SEGMENTS;
         y0 = curve_at(p0);
         y1 = curve_at(p1);
         y  = y0;
         if (p1 > p0 && y1 > y0 && u > p0) y += ((y1 - y0) * (u - p0)) / (p1 - p0);
         return y > 65535 ? 65535 : y;
      endfunction

      function void accept_item(req_type t);
         rsp_type want;
         longint  dot, prob;
         if (t.mode == MODE_WEIGHT) begin
            weight_mem[t.weight_index] = t.value;
            return;
         end
         if (element_pos < DEPTH) begin
            dot_sum += longint'($signed(weight_mem[element_pos])) * longint'($signed(t.value));
            if (dot_sum > longint'(ACC_MAX)) dot_sum = longint'(ACC_MAX);
            if (dot_sum < longint'(ACC_MIN)) dot_sum = longint'(ACC_MIN);
            element_pos++;
         end else begin
            past_depth = 1;
         end
         if (!t.last) return;
         dot = dot_sum;
         want.sum_saturated = 1'b0;
         if (dot > longint'(DOT_MAX)) begin
            dot = longint'(DOT_MAX);
            want.sum_saturated = 1'b1;
         end else if (dot < longint'(DOT_MIN)) begin
            dot = longint'(DOT_MIN);
            want.sum_saturated = 1'b1;
         end
         prob                   = probability_of(dot);
         want.probability       = prob[15:0];
         want.dot_product       = dot[31:0];
         want.too_many_features = past_depth;
         expected_scores.push_back(want);
         dot_sum     = 0;
         element_pos = 0;
         past_depth  = 0;
      endfunction

      function void check_score(rsp_type got);
         rsp_type want;
         if (expected_scores.size() == 0) begin
            $display("%0t: result with none expected, got %h", $time, got);
            errors++;
            return;
         end
         want = expected_scores.pop_front();
         if (got.probability !== want.probability) begin
            $display("%0t: probability expected %0d got %0d", $time,
                     want.probability, got.probability);
            errors++;
         end
         if (got.dot_product !== want.dot_product) begin
            $display("%0t: dot_product expected %0d got %0d", $time,
                     want.dot_product, got.dot_product);
            errors++;
         end
         if (got.sum_saturated !== want.sum_saturated) begin
            $display("%0t: sum_saturated expected %0b got %0b", $time,
                     want.sum_saturated, got.sum_saturated);
            errors++;
         end
         if (got.too_many_features !== want.too_many_features) begin
            $display("%0t: too_many_features expected %0b got %0b", $time,
                     want.too_many_features, got.too_many_features);
            errors++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   probability_tracker board;
   int idle_pct    = 0;
   int stall_pct   = 0;
   int sent_items  = 0;

   logistic_regression_predict DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_score(rsp_data);
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   // one transaction on the request channel; returns at the accepting edge
   task automatic send_req(req_type t);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      do @(posedge clock); while (req_stall);
      board.accept_item(t);
      sent_items++;
   endtask

   task automatic send_weight(int idx, logic signed [15:0] val, bit last);
      req_type t;
      t.mode         = MODE_WEIGHT;
      t.weight_index = 6'(idx);
      t.value        = val;
      t.last         = last;
      send_req(t);
   endtask

   task automatic send_feature(logic signed [15:0] val, bit last);
      req_type t;
      t.mode         = MODE_FEATURE;
      t.weight_index = 6'($urandom_range(63));
      t.value        = val;
      t.last         = last;
      send_req(t);
   endtask

   // hold off the sender until all outstanding results are back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.expected_scores.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [15:0] rand_value(int cls);
      case (cls)
         0: return 16'($urandom_range(65535));
         1: return 16'($urandom_range(8192) - 4096);
         default: return 16'($urandom_range(1024) - 512);
      endcase
   endfunction

   task automatic run_random(int target);
      int pick, len, fcls;
      while (sent_items < target) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            repeat ($urandom_range(1, 8))
               send_weight($urandom_range(63), rand_value($urandom_range(2)),
                           $urandom_range(1));
         end else begin
            pick = $urandom_range(99);
            len  = pick < 60 ? $urandom_range(1, 8) :
                   pick < 85 ? $urandom_range(9, 40) :
                   pick < 95 ? DEPTH : $urandom_range(DEPTH + 1, DEPTH + 8);
            fcls = $urandom_range(2);
            for (int i = 1; i <= len; i++) begin
               // occasional weight update in the middle of a vector
               if ($urandom_range(99) < 4)
                  send_weight($urandom_range(63), rand_value($urandom_range(2)),
                              $urandom_range(1));
               send_feature(rand_value(fcls), i == len);
            end
         end
      end
   endtask

   initial begin
      board     = new;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      rsp_stall <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // every weight entry is written before any feature reads it
      for (int i = 0; i < DEPTH; i++)
         send_weight(i, rand_value($urandom_range(2)), $urandom_range(1));

      // extreme weights and features; last is ignored on weight writes
      send_weight(0, 16'sh7FFF, 1'b1);
      send_weight(1, 16'sh8000, 1'b0);
      send_feature(16'sh7FFF, 1'b0);
      send_feature(16'sh8000, 1'b1);
      // single element, far below -8
      send_feature(16'sh8000, 1'b1);
      // zero dot product, curve midpoint
      send_feature(16'sh0000, 1'b1);
      // 32-bit clip, positive then negative
      send_weight(0, 16'sh8000, 1'b0);
      send_weight(1, 16'sh8000, 1'b0);
      send_weight(2, 16'sh8000, 1'b0);
      send_feature(16'sh8000, 1'b0);
      send_feature(16'sh8000, 1'b0);
      send_feature(16'sh8000, 1'b1);
      send_feature(16'sh7FFF, 1'b0);
      send_feature(16'sh7FFF, 1'b0);
      send_feature(16'sh7FFF, 1'b1);
      // exactly +8, exactly -8, just below +8
      send_weight(0, 16'sd16384, 1'b0);
      send_feature(16'sd8192, 1'b1);
      send_feature(-16'sd8192, 1'b1);
      send_feature(16'sd8191, 1'b1);
      // z = 0.5 lands on a breakpoint
      send_weight(0, 16'sd4096, 1'b0);
      send_feature(16'sd2048, 1'b1);

      run_random(450);
      drain();
      idle_pct = 78;
      run_random(900);
      drain();
      idle_pct  = 0;
      stall_pct = 78;
      run_random(1350);
      drain();
      idle_pct  = 35;
      stall_pct = 35;
      run_random(1800);

      drain();
      repeat (20) @(posedge clock);
      if (board.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
